[src/assert_macros.svh]
// Assertion macros shared by the receiver RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CHK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CHK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

[src/ifrag_pkg.sv]
// Types and constants of the information frame receiver.
// Used by every module of the block; depends on nothing.
package ifrag_pkg;

	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_FLAG      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLAG_SUB  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ESC_SUB   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CTRL_ZERO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CTRL_ONE  = 3'd6;

	localparam logic [7:0] RST_FLAG      = 8'h7E;
	localparam logic [7:0] RST_ESCAPE    = 8'h7D;
	localparam logic [7:0] RST_FLAG_SUB  = 8'h5E;
	localparam logic [7:0] RST_ESC_SUB   = 8'h5D;
	localparam logic [7:0] RST_ADDRESS   = 8'h03;
	localparam logic [7:0] RST_CTRL_ZERO = 8'h00;
	localparam logic [7:0] RST_CTRL_ONE  = 8'h40;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	localparam logic RESP_RR  = 1'b0;
	localparam logic RESP_REJ = 1'b1;

	typedef struct packed {
		logic [7:0] flag_byte;
		logic [7:0] escape_byte;
		logic [7:0] flag_substitute;
		logic [7:0] escape_substitute;
		logic [7:0] sender_address;
		logic [7:0] info_control_zero;
		logic [7:0] info_control_one;
	} cfg_t;

	// Classified word passed from the front to the back
	typedef struct packed {
		logic       close;
		logic [7:0] data;
		logic       seq;
	} tok_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] payload;
		logic       seq;
		logic       ok;
		logic       resp_kind;
		logic       resp_seq;
		logic       deliver;
	} out_item_t;

endpackage

[src/ifrag_front.sv]
// Front end: frame hunt, header check and destuffing of received bytes.
// Depends on ifrag_pkg and assert_macros.svh; feeds ifrag_queue.
`include "assert_macros.svh"

module ifrag_front (
	input  logic              clk,
	input  logic              arst_n,
	input  ifrag_pkg::cfg_t   cfg,
	input  logic              byte_accept,
	input  logic [7:0]        byte_in,
	output logic              push_valid,
	output ifrag_pkg::tok_t   push_tok
);

	localparam logic [2:0] HS_WAIT = 3'd0;
	localparam logic [2:0] HS_FLAG = 3'd1;
	localparam logic [2:0] HS_ADDR = 3'd2;
	localparam logic [2:0] HS_CTRL = 3'd3;
	localparam logic [2:0] HS_DATA = 3'd4;

	logic [2:0] hs_q, hs_d;
	logic       esc_q, esc_d;
	logic       seq_q, seq_d;
	logic       push_c;
	logic [7:0] tok_data_c;
	logic       tok_close_c;
	logic [7:0] ctrl_c;

	assign ctrl_c = seq_q ? cfg.info_control_one : cfg.info_control_zero;

	always_comb begin
		hs_d        = hs_q;
		esc_d       = esc_q;
		seq_d       = seq_q;
		push_c      = 1'b0;
		tok_close_c = 1'b0;
		tok_data_c  = byte_in;
		unique case (hs_q)
			HS_FLAG: begin
				if (byte_in == cfg.sender_address) hs_d = HS_ADDR;
				else if (byte_in != cfg.flag_byte) hs_d = HS_WAIT;
			end
			HS_ADDR: begin
				priority if (byte_in == cfg.info_control_zero) begin
					seq_d = 1'b0;
					hs_d  = HS_CTRL;
				end else if (byte_in == cfg.info_control_one) begin
					seq_d = 1'b1;
					hs_d  = HS_CTRL;
				end else if (byte_in == cfg.flag_byte) begin
					hs_d = HS_FLAG;
				end else begin
					hs_d = HS_WAIT;
				end
			end
			HS_CTRL: begin
				priority if ((cfg.sender_address ^ ctrl_c) == byte_in) begin
					esc_d = 1'b0;
					hs_d  = HS_DATA;
				end else if (byte_in == cfg.flag_byte) begin
					hs_d = HS_FLAG;
				end else begin
					hs_d = HS_WAIT;
				end
			end
			HS_DATA: begin
				priority if (byte_in == cfg.flag_byte) begin
					push_c      = 1'b1;
					tok_close_c = 1'b1;
					esc_d       = 1'b0;
					hs_d        = HS_WAIT;
				end else if (esc_q) begin
					esc_d = 1'b0;
					// restore stuffed byte; drop an invalid pair
					if (byte_in == cfg.flag_substitute) begin
						push_c     = 1'b1;
						tok_data_c = cfg.flag_byte;
					end else if (byte_in == cfg.escape_substitute) begin
						push_c     = 1'b1;
						tok_data_c = cfg.escape_byte;
					end
				end else if (byte_in == cfg.escape_byte) begin
					esc_d = 1'b1;
				end else begin
					push_c = 1'b1;
				end
			end
			default: begin
				if (byte_in == cfg.flag_byte) hs_d = HS_FLAG;
				else hs_d = HS_WAIT;
			end
		endcase
	end

	assign push_valid     = byte_accept && push_c;
	assign push_tok.close = tok_close_c;
	assign push_tok.data  = tok_data_c;
	assign push_tok.seq   = seq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_q  <= HS_WAIT;
			esc_q <= 1'b0;
			seq_q <= 1'b0;
		end else if (byte_accept) begin
			hs_q  <= hs_d;
			esc_q <= esc_d;
			seq_q <= seq_d;
		end
	end

	`ASSERT_CHK(a_close_to_wait, clk, arst_n, (push_valid && push_tok.close) |=> (hs_q == HS_WAIT))
	`ASSERT_NEVER(a_push_outside_data, clk, arst_n, push_valid && (hs_q != HS_DATA))
	`ASSERT_NEVER(a_escape_outside_data, clk, arst_n, esc_q && (hs_q != HS_DATA))

endmodule

[src/ifrag_queue.sv]
// Short word queue between the front end and the back end.
// Depends on ifrag_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ifrag_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ifrag_pkg::tok_t   push_tok,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output ifrag_pkg::tok_t   head_tok
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	ifrag_pkg::tok_t   slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_tok   = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	`ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > CNT_W'(DEPTH))
	`ASSERT_CHK(a_empty_holds, clk, arst_n, (count_q == '0 && !push) |=> (count_q == '0))
	`ASSERT_NEVER(a_push_lost, clk, arst_n, push && full)

endmodule

[src/ifrag_back.sv]
// Back end: one-byte hold-back, block check XOR, verdict and output register.
// Depends on ifrag_pkg and assert_macros.svh; drained from ifrag_queue.
`include "assert_macros.svh"

module ifrag_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  tok_valid,
	input  ifrag_pkg::tok_t       tok,
	output logic                  tok_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ifrag_pkg::out_item_t  out_item
);

	logic [7:0]            held_q;
	logic                  held_valid_q;
	logic [7:0]            xor_q;
	logic                  exp_seq_q;
	logic                  out_valid_q;
	ifrag_pkg::out_item_t  out_q;

	logic                  slot_free;
	logic                  emit_c;
	logic                  ok_c, expected_c, rej_c, deliver_c;
	ifrag_pkg::out_item_t  item_c;

	assign slot_free = !out_valid_q || !out_stall;
	assign tok_pop   = tok_valid && slot_free;

	assign ok_c       = held_valid_q && (xor_q == held_q);
	assign expected_c = (tok.seq == exp_seq_q);
	assign rej_c      = !ok_c && expected_c;
	assign deliver_c  = ok_c && expected_c;
	assign emit_c     = tok.close || held_valid_q;

	always_comb begin
		if (tok.close) begin
			item_c.kind      = ifrag_pkg::KIND_VERDICT;
			item_c.payload   = 8'h00;
			item_c.seq       = tok.seq;
			item_c.ok        = ok_c;
			item_c.resp_kind = rej_c ? ifrag_pkg::RESP_REJ : ifrag_pkg::RESP_RR;
			item_c.resp_seq  = rej_c ? tok.seq : !tok.seq;
			item_c.deliver   = deliver_c;
		end else begin
			item_c.kind      = ifrag_pkg::KIND_PAYLOAD;
			item_c.payload   = held_q;
			item_c.seq       = tok.seq;
			item_c.ok        = 1'b0;
			item_c.resp_kind = ifrag_pkg::RESP_RR;
			item_c.resp_seq  = 1'b0;
			item_c.deliver   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			held_valid_q <= 1'b0;
			xor_q        <= '0;
			exp_seq_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (tok_pop) begin
				if (tok.close) begin
					held_q       <= '0;
					held_valid_q <= 1'b0;
					xor_q        <= '0;
					if (deliver_c) exp_seq_q <= !exp_seq_q;
				end else begin
					if (held_valid_q) xor_q <= xor_q ^ held_q;
					held_q       <= tok.data;
					held_valid_q <= 1'b1;
				end
			end
			if (slot_free) out_valid_q <= tok_pop && emit_c;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_pop && emit_c) out_q <= item_c;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`ASSERT_CHK(a_close_clears, clk, arst_n, (tok_pop && tok.close) |=> !held_valid_q)
	`ASSERT_CHK(a_verdict_shown, clk, arst_n, (tok_pop && tok.close) |=> out_valid_q)
	`ASSERT_NEVER(a_deliver_needs_ok, clk, arst_n, out_valid_q && out_q.deliver && !out_q.ok)

endmodule

[src/info_frame_receiver_ack_gen_unit.sv]
// Top level of the information frame receiver with acknowledge generation.
// Depends on ifrag_pkg, ifrag_front, ifrag_queue and ifrag_back.
//
//   channel  direction  handshake            payload
//   rx       in         rx_valid/rx_stall    rx_byte
//   out      out        out_valid/out_stall  out_kind .. deliver
//   cfg      in         cfg_wr_en            cfg_index, cfg_data
//
// One received byte is taken every cycle while the word queue has room.
// Each word is registered in the word queue, then in the back end's output register.
// Reset (arst_n low) returns the hunt to waiting for a flag, empties the queue
// and restores the register defaults.
// out_stall holds the output register; rx_stall rises only once the queue is full.
module info_frame_receiver_ack_gen_unit #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              rx_valid,
	output logic                              rx_stall,
	input  logic [7:0]                        rx_byte,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              out_kind,
	output logic [7:0]                        payload_byte,
	output logic                              frame_seq,
	output logic                              check_ok,
	output logic                              response_kind,
	output logic                              response_seq,
	output logic                              deliver,
	input  logic                              cfg_wr_en,
	input  logic [ifrag_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                        cfg_data
);

	ifrag_pkg::cfg_t       cfg_q;
	logic                  rx_accept;
	logic                  push_valid;
	ifrag_pkg::tok_t       push_tok;
	logic                  q_full;
	logic                  head_valid;
	ifrag_pkg::tok_t       head_tok;
	logic                  head_pop;
	ifrag_pkg::out_item_t  out_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag_byte         <= ifrag_pkg::RST_FLAG;
			cfg_q.escape_byte       <= ifrag_pkg::RST_ESCAPE;
			cfg_q.flag_substitute   <= ifrag_pkg::RST_FLAG_SUB;
			cfg_q.escape_substitute <= ifrag_pkg::RST_ESC_SUB;
			cfg_q.sender_address    <= ifrag_pkg::RST_ADDRESS;
			cfg_q.info_control_zero <= ifrag_pkg::RST_CTRL_ZERO;
			cfg_q.info_control_one  <= ifrag_pkg::RST_CTRL_ONE;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ifrag_pkg::CFG_FLAG:      cfg_q.flag_byte         <= cfg_data;
				ifrag_pkg::CFG_ESCAPE:    cfg_q.escape_byte       <= cfg_data;
				ifrag_pkg::CFG_FLAG_SUB:  cfg_q.flag_substitute   <= cfg_data;
				ifrag_pkg::CFG_ESC_SUB:   cfg_q.escape_substitute <= cfg_data;
				ifrag_pkg::CFG_ADDRESS:   cfg_q.sender_address    <= cfg_data;
				ifrag_pkg::CFG_CTRL_ZERO: cfg_q.info_control_zero <= cfg_data;
				ifrag_pkg::CFG_CTRL_ONE:  cfg_q.info_control_one  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rx_stall  = q_full;
	assign rx_accept = rx_valid && !q_full;

	ifrag_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.byte_accept (rx_accept),
		.byte_in     (rx_byte),
		.push_valid  (push_valid),
		.push_tok    (push_tok)
	);

	ifrag_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push_valid),
		.push_tok   (push_tok),
		.full       (q_full),
		.pop        (head_pop),
		.head_valid (head_valid),
		.head_tok   (head_tok)
	);

	ifrag_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (head_valid),
		.tok       (head_tok),
		.tok_pop   (head_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	assign out_kind      = out_item.kind;
	assign payload_byte  = out_item.payload;
	assign frame_seq     = out_item.seq;
	assign check_ok      = out_item.ok;
	assign response_kind = out_item.resp_kind;
	assign response_seq  = out_item.resp_seq;
	assign deliver       = out_item.deliver;

endmodule

[bench/ifrag_checker.sv]
// Checker for the information frame receiver: watches the rx, out and cfg ports,
// predicts every result word and compares it with what the block returns.
// Depends on ifrag_pkg only.
module ifrag_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rx_valid,
	input  logic                            rx_stall,
	input  logic [7:0]                      rx_byte,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic                            out_kind,
	input  logic [7:0]                      payload_byte,
	input  logic                            frame_seq,
	input  logic                            check_ok,
	input  logic                            response_kind,
	input  logic                            response_seq,
	input  logic                            deliver,
	input  logic                            cfg_wr_en,
	input  logic [ifrag_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                      cfg_data,
	output int unsigned                     fail_count,
	output int unsigned                     pending
);

	typedef enum logic [2:0] {
		LINE_IDLE,
		LINE_FLAG,
		LINE_ADDR,
		LINE_CTRL,
		LINE_DATA
	} hunt_t;

	ifrag_pkg::cfg_t        regs;
	hunt_t                  hunt;
	logic                   esc_seen;
	logic                   cur_seq;
	logic                   want_seq;
	logic [7:0]             held;
	logic                   held_ok;
	logic [7:0]             xor_acc;
	ifrag_pkg::out_item_t   due_q[$];
	ifrag_pkg::out_item_t   seen;
	ifrag_pkg::out_item_t   owed;
	int unsigned            errors;

	assign fail_count = errors;
	assign pending    = due_q.size();

	task automatic restart_field();
		esc_seen = 1'b0;
		held     = 8'h00;
		held_ok  = 1'b0;
		xor_acc  = 8'h00;
	endtask

	// release the previously held word as payload, hold the new one as candidate check
	task automatic hold_word(input logic [7:0] d);
		ifrag_pkg::out_item_t it;
		if (held_ok) begin
			xor_acc    = xor_acc ^ held;
			it         = '0;
			it.kind    = ifrag_pkg::KIND_PAYLOAD;
			it.payload = held;
			it.seq     = cur_seq;
			due_q.push_back(it);
		end
		held    = d;
		held_ok = 1'b1;
	endtask

	task automatic absorb_line_word(input logic [7:0] b);
		ifrag_pkg::out_item_t  it;
		logic                  good;
		logic                  fresh;
		logic [7:0]            ctrl;
		case (hunt)
			LINE_FLAG: begin
				if (b == regs.sender_address) hunt = LINE_ADDR;
				else if (b != regs.flag_byte) hunt = LINE_IDLE;
			end
			LINE_ADDR: begin
				if (b == regs.info_control_zero) begin
					cur_seq = 1'b0;
					hunt    = LINE_CTRL;
				end else if (b == regs.info_control_one) begin
					cur_seq = 1'b1;
					hunt    = LINE_CTRL;
				end else if (b == regs.flag_byte) hunt = LINE_FLAG;
				else hunt = LINE_IDLE;
			end
			LINE_CTRL: begin
				ctrl = cur_seq ? regs.info_control_one : regs.info_control_zero;
				if ((regs.sender_address ^ ctrl) == b) begin
					restart_field();
					hunt = LINE_DATA;
				end else if (b == regs.flag_byte) hunt = LINE_FLAG;
				else hunt = LINE_IDLE;
			end
			LINE_DATA: begin
				if (b == regs.flag_byte) begin
					good    = held_ok && (xor_acc == held);
					fresh   = (cur_seq == want_seq);
					it      = '0;
					it.kind = ifrag_pkg::KIND_VERDICT;
					it.seq  = cur_seq;
					it.ok   = good;
					if (good || !fresh) begin
						it.resp_kind = ifrag_pkg::RESP_RR;
						it.resp_seq  = ~cur_seq;
					end else begin
						it.resp_kind = ifrag_pkg::RESP_REJ;
						it.resp_seq  = cur_seq;
					end
					it.deliver = good && fresh;
					due_q.push_back(it);
					if (it.deliver) want_seq = ~want_seq;
					restart_field();
					hunt = LINE_IDLE;
				end else if (esc_seen) begin
					esc_seen = 1'b0;
					if (b == regs.flag_substitute) hold_word(regs.flag_byte);
					else if (b == regs.escape_substitute) hold_word(regs.escape_byte);
				end else if (b == regs.escape_byte) begin
					esc_seen = 1'b1;
				end else begin
					hold_word(b);
				end
			end
			default: hunt = (b == regs.flag_byte) ? LINE_FLAG : LINE_IDLE;
		endcase
	endtask

	task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '{ifrag_pkg::RST_FLAG, ifrag_pkg::RST_ESCAPE, ifrag_pkg::RST_FLAG_SUB,
				ifrag_pkg::RST_ESC_SUB, ifrag_pkg::RST_ADDRESS, ifrag_pkg::RST_CTRL_ZERO,
				ifrag_pkg::RST_CTRL_ONE};
			hunt     = LINE_IDLE;
			cur_seq  = 1'b0;
			want_seq = 1'b0;
			restart_field();
			due_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				seen.kind      = out_kind;
				seen.payload   = payload_byte;
				seen.seq       = frame_seq;
				seen.ok        = check_ok;
				seen.resp_kind = response_kind;
				seen.resp_seq  = response_seq;
				seen.deliver   = deliver;
				if (due_q.size() == 0) begin
					errors++;
					$display("%0t: result word with none expected, got kind %0d payload %0h",
						$time, seen.kind, seen.payload);
				end else begin
					owed = due_q.pop_front();
					compare_field("out_kind", 8'(owed.kind), 8'(seen.kind));
					compare_field("payload_byte", owed.payload, seen.payload);
					compare_field("frame_seq", 8'(owed.seq), 8'(seen.seq));
					compare_field("check_ok", 8'(owed.ok), 8'(seen.ok));
					compare_field("response_kind", 8'(owed.resp_kind), 8'(seen.resp_kind));
					compare_field("response_seq", 8'(owed.resp_seq), 8'(seen.resp_seq));
					compare_field("deliver", 8'(owed.deliver), 8'(seen.deliver));
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					ifrag_pkg::CFG_FLAG:      regs.flag_byte         = cfg_data;
					ifrag_pkg::CFG_ESCAPE:    regs.escape_byte       = cfg_data;
					ifrag_pkg::CFG_FLAG_SUB:  regs.flag_substitute   = cfg_data;
					ifrag_pkg::CFG_ESC_SUB:   regs.escape_substitute = cfg_data;
					ifrag_pkg::CFG_ADDRESS:   regs.sender_address    = cfg_data;
					ifrag_pkg::CFG_CTRL_ZERO: regs.info_control_zero = cfg_data;
					ifrag_pkg::CFG_CTRL_ONE:  regs.info_control_one  = cfg_data;
					default: ;
				endcase
			end
			if (rx_valid && rx_stall === 1'b0) absorb_line_word(rx_byte);
		end
	end

endmodule

[bench/tb_info_frame_receiver_ack_gen_unit.sv]
// Testbench top for info_frame_receiver_ack_gen_unit: drives framed and broken
// byte streams under several register settings and idle patterns.
// Depends on ifrag_pkg, the block itself and ifrag_checker.
module tb_info_frame_receiver_ack_gen_unit;

	typedef enum int {
		FLAW_NONE,
		FLAW_BAD_CHECK,
		FLAW_NO_CHECK,
		FLAW_BAD_ESCAPE,
		FLAW_ESC_CLOSE
	} flaw_t;

	localparam logic [ifrag_pkg::CFG_IDX_W-1:0] REG_ORDER [7] = '{ifrag_pkg::CFG_FLAG,
		ifrag_pkg::CFG_ESCAPE, ifrag_pkg::CFG_FLAG_SUB, ifrag_pkg::CFG_ESC_SUB,
		ifrag_pkg::CFG_ADDRESS, ifrag_pkg::CFG_CTRL_ZERO, ifrag_pkg::CFG_CTRL_ONE};

	logic                            clk;
	logic                            arst_n;
	logic                            rx_valid;
	logic                            rx_stall;
	logic [7:0]                      rx_byte;
	logic                            out_valid;
	logic                            out_stall;
	logic                            out_kind;
	logic [7:0]                      payload_byte;
	logic                            frame_seq;
	logic                            check_ok;
	logic                            response_kind;
	logic                            response_seq;
	logic                            deliver;
	logic                            cfg_wr_en;
	logic [ifrag_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [7:0]                      cfg_data;
	int unsigned                     fail_count;
	int unsigned                     pending;

	int unsigned       send_idle_pct;
	int unsigned       recv_idle_pct;
	int unsigned       words_sent;
	ifrag_pkg::cfg_t   line_cfg;

	info_frame_receiver_ack_gen_unit u_dut (.*);
	ifrag_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#1_600_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	task automatic send_word(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (rx_stall !== 1'b0) @(posedge clk);
		words_sent++;
	endtask

	task automatic settle();
		rx_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_regs(input ifrag_pkg::cfg_t c);
		logic [7:0] vals [7];
		vals = '{c.flag_byte, c.escape_byte, c.flag_substitute, c.escape_substitute,
			c.sender_address, c.info_control_zero, c.info_control_one};
		for (int i = 0; i < 7; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= REG_ORDER[i];
			cfg_data  <= vals[i];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		line_cfg = c;
	endtask

	function automatic logic [7:0] pick_word();
		case ($urandom_range(0, 9))
			0: return line_cfg.flag_byte;
			1: return line_cfg.escape_byte;
			2: return line_cfg.flag_substitute;
			3: return line_cfg.escape_substitute;
			4: return line_cfg.sender_address;
			5: return line_cfg.info_control_zero;
			6: return line_cfg.info_control_one;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic ifrag_pkg::cfg_t random_regs();
		ifrag_pkg::cfg_t c;
		c.flag_byte         = 8'($urandom_range(0, 255));
		c.escape_byte       = 8'($urandom_range(0, 255));
		c.flag_substitute   = 8'($urandom_range(0, 255));
		c.escape_substitute = 8'($urandom_range(0, 255));
		c.sender_address    = 8'($urandom_range(0, 255));
		c.info_control_zero = 8'($urandom_range(0, 255));
		c.info_control_one  = 8'($urandom_range(0, 255));
		return c;
	endfunction

	task automatic send_stuffed(input logic [7:0] d);
		if (d == line_cfg.flag_byte) begin
			send_word(line_cfg.escape_byte);
			send_word(line_cfg.flag_substitute);
		end else if (d == line_cfg.escape_byte) begin
			send_word(line_cfg.escape_byte);
			send_word(line_cfg.escape_substitute);
		end else begin
			send_word(d);
		end
	endtask

	task automatic send_frame(input int n_data, input logic seq, input flaw_t flaw);
		logic [7:0] ctrl;
		logic [7:0] acc;
		logic [7:0] d;
		ctrl = seq ? line_cfg.info_control_one : line_cfg.info_control_zero;
		send_word(line_cfg.flag_byte);
		if ($urandom_range(0, 3) == 0) send_word(line_cfg.flag_byte);
		send_word(line_cfg.sender_address);
		send_word(ctrl);
		send_word(line_cfg.sender_address ^ ctrl);
		acc = 8'h00;
		for (int i = 0; i < n_data; i++) begin
			d   = pick_word();
			acc = acc ^ d;
			send_stuffed(d);
			if (flaw == FLAW_BAD_ESCAPE && i == 0) begin
				send_word(line_cfg.escape_byte);
				send_word(8'($urandom_range(0, 255)));
			end
		end
		if (flaw == FLAW_BAD_CHECK) send_stuffed(acc ^ 8'($urandom_range(1, 255)));
		else if (flaw != FLAW_NO_CHECK) send_stuffed(acc);
		if (flaw == FLAW_ESC_CLOSE) send_word(line_cfg.escape_byte);
		send_word(line_cfg.flag_byte);
	endtask

	task automatic run_traffic(input int unsigned budget);
		int unsigned stop;
		int unsigned r;
		int          n;
		flaw_t       flaw;
		stop = words_sent + budget;
		while (words_sent < stop) begin
			r = $urandom_range(0, 99);
			n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(6, 14))
				: int'($urandom_range(0, 4));
			if (r < 83) begin
				if (r < 55) flaw = FLAW_NONE;
				else if (r < 67) flaw = FLAW_BAD_CHECK;
				else if (r < 72) flaw = FLAW_NO_CHECK;
				else if (r < 78) flaw = FLAW_BAD_ESCAPE;
				else flaw = FLAW_ESC_CLOSE;
				send_frame(n, 1'($urandom_range(0, 1)), flaw);
			end else if (r < 92) begin
				repeat ($urandom_range(1, 4)) send_word(pick_word());
			end else begin
				send_word(line_cfg.flag_byte);
				send_word(line_cfg.sender_address);
				send_word(pick_word());
				send_word(pick_word());
			end
		end
	endtask

	initial begin
		logic [7:0] opening [] = '{
			8'h7E, 8'h7E, 8'h03, 8'h00, 8'h03, 8'hFF, 8'h7D, 8'h5E, 8'h7D, 8'h11, 8'h7D, 8'h7E,
			8'h7E, 8'h03, 8'h40, 8'h43, 8'h7E,
			8'h7E, 8'h55, 8'h7E, 8'h03, 8'h7E, 8'h03, 8'h00, 8'h99,
			8'h7E, 8'h03, 8'h00, 8'h03, 8'h00, 8'h7E};
		ifrag_pkg::cfg_t c;
		arst_n    <= 1'b0;
		rx_valid  <= 1'b0;
		rx_byte   <= 8'h00;
		cfg_wr_en <= 1'b0;
		cfg_index <= ifrag_pkg::CFG_FLAG;
		cfg_data  <= 8'h00;
		words_sent    = 0;
		send_idle_pct = 18;
		recv_idle_pct = 81;
		line_cfg = '{ifrag_pkg::RST_FLAG, ifrag_pkg::RST_ESCAPE, ifrag_pkg::RST_FLAG_SUB,
			ifrag_pkg::RST_ESC_SUB, ifrag_pkg::RST_ADDRESS, ifrag_pkg::RST_CTRL_ZERO,
			ifrag_pkg::RST_CTRL_ONE};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i]) send_word(opening[i]);
		run_traffic(40);
		settle();

		for (int s = 0; s < 6; s++) begin
			if (s == 2) begin
				send_idle_pct = 81;
				recv_idle_pct = 18;
			end else if (s == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (s)
				0: c = random_regs();
				1: c = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF};
				2: begin
					c = random_regs();
					c.info_control_one = c.info_control_zero;
				end
				3: begin
					c = random_regs();
					c.escape_byte       = c.flag_byte;
					c.escape_substitute = c.flag_substitute;
				end
				4: c = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00};
				default: c = '{ifrag_pkg::RST_FLAG, ifrag_pkg::RST_ESCAPE,
					ifrag_pkg::RST_FLAG_SUB, ifrag_pkg::RST_ESC_SUB, ifrag_pkg::RST_ADDRESS,
					ifrag_pkg::RST_CTRL_ZERO, ifrag_pkg::RST_CTRL_ONE};
			endcase
			write_regs(c);
			run_traffic(65);
			settle();
		end

		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/ifrag_pkg.sv
src/ifrag_front.sv
src/ifrag_queue.sv
src/ifrag_back.sv
src/info_frame_receiver_ack_gen_unit.sv
bench/ifrag_checker.sv
bench/tb_info_frame_receiver_ack_gen_unit.sv
